### hdl/hcf_pkg.sv
// Package with the types, constants and helper functions of the chunked transfer framer.
package hcf_pkg;

  localparam int unsigned CountWidthDef = 48;
  localparam int unsigned HdrBitsCap    = 44;

  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned BktLenW  = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PlenW    = 48;

  localparam logic [ByteW-1:0] ChrCr   = 8'h0d;
  localparam logic [ByteW-1:0] ChrLf   = 8'h0a;
  localparam logic [ByteW-1:0] ChrZero = 8'h30;
  localparam logic [ByteW-1:0] ChrA    = 8'h61;

  typedef enum logic [ReqTypeW-1:0] {
    RT_DATA  = 3'd0,
    RT_FLUSH = 3'd1,
    RT_EOS   = 3'd2,
    RT_BADGW = 3'd3,
    RT_GROUP = 3'd4
  } req_type_e;

  typedef enum logic [KindW-1:0] {
    TK_BYTE  = 2'd0,
    TK_SLOT  = 2'd1,
    TK_FLUSH = 2'd2,
    TK_EOS   = 2'd3
  } token_kind_e;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_FLUSH,
    TAIL_EOS,
    TAIL_EOS_TERM
  } tail_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIGIT,
    S_HCR,
    S_HLF,
    S_SLOT,
    S_TCR,
    S_TLF,
    S_Z0,
    S_Z1,
    S_Z2,
    S_Z3,
    S_Z4,
    S_MARK
  } seq_state_e;

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] res;
    if (nib < 4'd10) begin
      res = ChrZero + ByteW'(nib);
    end else begin
      res = ChrA + ByteW'(nib - 4'd10);
    end
    return res;
  endfunction

  function automatic seq_state_e tail_entry(input tail_e tail);
    seq_state_e res;
    unique case (tail)
      TAIL_NONE:     res = S_IDLE;
      TAIL_FLUSH:    res = S_MARK;
      TAIL_EOS:      res = S_MARK;
      TAIL_EOS_TERM: res = S_Z0;
      default:       res = S_IDLE;
    endcase
    return res;
  endfunction

endpackage

### hdl/hcf_req_if.sv
// Valid/ready channel that carries one bucket descriptor per beat.
interface hcf_req_if import hcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [BktLenW-1:0]  bucket_length;
  logic                break_after;

  modport source (output valid, output req_type, output bucket_length, output break_after,
                  input ready);
  modport sink   (input valid, input req_type, input bucket_length, input break_after,
                  output ready);
endinterface

### hdl/hcf_tok_if.sv
// Valid/ready channel that carries one framing token per beat.
interface hcf_tok_if import hcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] token_kind;
  logic [ByteW-1:0] frame_byte;
  logic [PlenW-1:0] payload_length;
  logic             count_overflow;
  logic             last;

  modport source (output valid, output token_kind, output frame_byte, output payload_length,
                  output count_overflow, output last, input ready);
  modport sink   (input valid, input token_kind, input frame_byte, input payload_length,
                  input count_overflow, input last, output ready);
endinterface

### hdl/http_chunked_framer_top.sv
// Chunked transfer framer: turns bucket descriptors into a stream of framing tokens.
//
// Data buckets only add to the running chunk count and are taken one per clock cycle while
// the sequencer is idle. A bucket that closes a chunk (flush, end of stream, end of group,
// or a nonempty data bucket with break-after) loads a token sequencer, which emits one
// token per cycle, unless the output stalls, into an output register: the hex length, CR LF,
// a payload slot, CR LF, the terminator and the marker, up to 22 tokens. While the sequencer
// runs the input is held, so the block takes no new item until the final token of the
// current one is in the output register. The output register lets the next item in while
// the final token still waits to be taken. The count saturates at 2^min(COUNT_WIDTH,44)-1
// and marks the overflow on every token of the closing chunk.
module http_chunked_framer_top
  import hcf_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hcf_req_if.sink      req_i,
  hcf_tok_if.source    tok_o
);

  localparam int unsigned LimBits   = (COUNT_WIDTH < HdrBitsCap) ? COUNT_WIDTH : HdrBitsCap;
  localparam int unsigned SumW      = ((LimBits > BktLenW) ? LimBits : BktLenW) + 1;
  localparam int unsigned HexDigits = (LimBits + 3) / 4;
  localparam int unsigned DigW      = (HexDigits > 1) ? $clog2(HexDigits) : 1;
  localparam logic [LimBits-1:0] Lim = '1;

  logic [LimBits-1:0] cnt_q, cnt_d;
  logic               ov_q, ov_d;
  logic               gw_q, gw_d;
  logic               closed_q, closed_d;

  logic [LimBits-1:0] job_cnt_q;
  logic               job_ov_q;
  tail_e              job_tail_q;
  logic [DigW-1:0]    dig_q;
  logic               first_q;
  seq_state_e         state_q, state_d;

  logic               out_valid_q;
  logic [KindW-1:0]   out_kind_q;
  logic [ByteW-1:0]   out_byte_q;
  logic [PlenW-1:0]   out_plen_q;
  logic               out_ov_q;
  logic               out_last_q;

  logic               in_acc;
  logic               out_free;
  logic               adv;

  logic [SumW-1:0]    sum;
  logic [LimBits-1:0] upd_cnt;
  logic               upd_ov;
  logic               close;
  logic               job_load;
  tail_e              job_tail;
  seq_state_e         job_start;

  logic [HexDigits*4-1:0] cnt_pad;
  logic [DigW-1:0]        top_idx;
  logic [DigW-1:0]        idx;
  logic [3:0]             nib;

  token_kind_e        tk_kind;
  logic [ByteW-1:0]   tk_byte;
  logic [PlenW-1:0]   tk_plen;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || tok_o.ready;
  assign adv         = (state_q != S_IDLE) && out_free;

  assign sum = SumW'(cnt_q) + SumW'(req_i.bucket_length);

  // Item decode and state update.
  always_comb begin
    cnt_d     = cnt_q;
    ov_d      = ov_q;
    gw_d      = gw_q;
    closed_d  = closed_q;
    upd_cnt   = cnt_q;
    upd_ov    = ov_q;
    close     = 1'b0;
    job_tail  = TAIL_NONE;
    if (in_acc && !closed_q) begin
      unique case (req_type_e'(req_i.req_type))
        RT_DATA: begin
          if (sum > SumW'(Lim)) begin
            upd_cnt = Lim;
            upd_ov  = 1'b1;
          end else begin
            upd_cnt = sum[LimBits-1:0];
          end
          cnt_d = upd_cnt;
          ov_d  = upd_ov;
          close = req_i.break_after && (req_i.bucket_length != '0);
        end
        RT_FLUSH: begin
          close    = 1'b1;
          job_tail = TAIL_FLUSH;
        end
        RT_EOS: begin
          close    = 1'b1;
          job_tail = gw_q ? TAIL_EOS : TAIL_EOS_TERM;
          closed_d = 1'b1;
        end
        RT_BADGW: begin
          gw_d = 1'b1;
        end
        RT_GROUP: begin
          close = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (close) begin
      cnt_d = '0;
      ov_d  = 1'b0;
    end
    job_load  = close && ((upd_cnt != '0) || (job_tail != TAIL_NONE));
    job_start = (upd_cnt != '0) ? S_DIGIT : tail_entry(job_tail);
  end

  // Hex digit selection.
  assign cnt_pad = (HexDigits*4)'(job_cnt_q);

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < HexDigits; i++) begin
      if (cnt_pad[i*4 +: 4] != 4'd0) begin
        top_idx = DigW'(i);
      end
    end
  end

  assign idx = first_q ? top_idx : dig_q;
  assign nib = cnt_pad[idx*4 +: 4];

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (job_load) state_d = job_start;
      S_DIGIT: if (adv && (idx == '0)) state_d = S_HCR;
      S_HCR:   if (adv) state_d = S_HLF;
      S_HLF:   if (adv) state_d = S_SLOT;
      S_SLOT:  if (adv) state_d = S_TCR;
      S_TCR:   if (adv) state_d = S_TLF;
      S_TLF:   if (adv) state_d = tail_entry(job_tail_q);
      S_Z0:    if (adv) state_d = S_Z1;
      S_Z1:    if (adv) state_d = S_Z2;
      S_Z2:    if (adv) state_d = S_Z3;
      S_Z3:    if (adv) state_d = S_Z4;
      S_Z4:    if (adv) state_d = S_MARK;
      S_MARK:  if (adv) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer token outputs.
  always_comb begin
    tk_kind = TK_BYTE;
    tk_byte = '0;
    tk_plen = '0;
    unique case (state_q)
      S_DIGIT: tk_byte = hex_char(nib);
      S_HCR:   tk_byte = ChrCr;
      S_HLF:   tk_byte = ChrLf;
      S_SLOT: begin
        tk_kind = TK_SLOT;
        tk_plen = PlenW'(job_cnt_q);
      end
      S_TCR:   tk_byte = ChrCr;
      S_TLF:   tk_byte = ChrLf;
      S_Z0:    tk_byte = ChrZero;
      S_Z1:    tk_byte = ChrCr;
      S_Z2:    tk_byte = ChrLf;
      S_Z3:    tk_byte = ChrCr;
      S_Z4:    tk_byte = ChrLf;
      S_MARK:  tk_kind = (job_tail_q == TAIL_FLUSH) ? TK_FLUSH : TK_EOS;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ov_q        <= 1'b0;
      gw_q        <= 1'b0;
      closed_q    <= 1'b0;
      state_q     <= S_IDLE;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
      gw_q     <= gw_d;
      closed_q <= closed_d;
      state_q  <= state_d;
      if (job_load) begin
        first_q <= 1'b1;
      end else if (adv && (state_q == S_DIGIT)) begin
        first_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (tok_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_cnt_q  <= upd_cnt;
      job_ov_q   <= upd_ov;
      job_tail_q <= job_tail;
    end
    if (adv && (state_q == S_DIGIT)) begin
      dig_q <= idx - DigW'(1);
    end
    if (adv) begin
      out_kind_q <= tk_kind;
      out_byte_q <= tk_byte;
      out_plen_q <= tk_plen;
      out_ov_q   <= job_ov_q;
      out_last_q <= (state_d == S_IDLE);
    end
  end

  assign tok_o.valid          = out_valid_q;
  assign tok_o.token_kind     = out_kind_q;
  assign tok_o.frame_byte     = out_byte_q;
  assign tok_o.payload_length = out_plen_q;
  assign tok_o.count_overflow = out_ov_q;
  assign tok_o.last           = out_last_q;

`ifndef NO_ASSERTIONS
  a_eos_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && (tok_o.token_kind == TK_EOS)) |-> closed_q)
    else $error("End-of-stream marker sent while the stream is still open.");

  a_slot_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && (tok_o.token_kind == TK_SLOT)) |-> (tok_o.payload_length != '0))
    else $error("Payload slot with zero length.");

  a_closed_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("Stream reopened after end of stream.");
`endif

endmodule
